// ----- rtl/atrc_pkg.sv -----
// ----------------------------------------------------------------------------
// atrc_pkg
// Shared types and constants for the AT reply line classifier: event codes,
// register indexes, fixed reply texts and the matcher status struct.
// ----------------------------------------------------------------------------
`default_nettype none

package atrc_pkg;

   localparam int WIN             = 16;
   localparam int LINE_MAX_DEF    = 256;
   localparam int PATTERN_MAX_DEF = 16;

   localparam int BYTE_W   = 8;
   localparam int PLEN_W   = 5;
   localparam int EVENT_W  = 3;
   localparam int LENGTH_W = 9;
   localparam int DATA_W   = 64;
   localparam int ADDR_W   = 5;
   localparam int INDEX_W  = 2;

   localparam int BLANK_LIMIT = 4;
   localparam int DATA_LIMIT  = 15;

   localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
   localparam logic [EVENT_W-1:0] EV_PROMPT    = 3'd1;
   localparam logic [EVENT_W-1:0] EV_BLANK     = 3'd2;
   localparam logic [EVENT_W-1:0] EV_MATCHED   = 3'd3;
   localparam logic [EVENT_W-1:0] EV_UNMATCHED = 3'd4;
   localparam logic [EVENT_W-1:0] EV_SERVER    = 3'd5;

   localparam logic [INDEX_W-1:0] REG_EXPECT_LOW  = 2'd0;
   localparam logic [INDEX_W-1:0] REG_EXPECT_HIGH = 2'd1;
   localparam logic [INDEX_W-1:0] REG_EXPECT_LEN  = 2'd2;

   localparam logic [DATA_W-1:0] EXPECT_LOW_RST  = 64'h0000_0000_0000_4B4F;
   localparam logic [DATA_W-1:0] EXPECT_HIGH_RST = 64'h0;
   localparam logic [PLEN_W-1:0] EXPECT_LEN_RST  = 5'd2;

   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_GT    = 8'h3E;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

   localparam int FAIL_LEN   = 12;
   localparam int CLOSED_LEN = 6;
   localparam logic [FAIL_LEN*BYTE_W-1:0]   FAIL_TEXT   = "CONNECT FAIL";
   localparam logic [CLOSED_LEN*BYTE_W-1:0] CLOSED_TEXT = "CLOSED";

   typedef logic [WIN-1:0][BYTE_W-1:0] window_type;

   typedef struct packed {
      logic expected;
      logic connect_fail;
      logic closed;
   } match_type;

endpackage

`default_nettype wire

// ----- rtl/atrc_match.sv -----
// ----------------------------------------------------------------------------
// atrc_match
// Compares the newest bytes of the line against the configured reply and the
// two fixed replies; a hit needs the whole pattern inside the current line.
// ----------------------------------------------------------------------------
`default_nettype none

module atrc_match #(
   parameter int CNT_W = 9
) (
   input  var atrc_pkg::window_type                     window,
   input  var logic [CNT_W-1:0]                         count,
   input  var logic [atrc_pkg::WIN*atrc_pkg::BYTE_W-1:0] pattern,
   input  var logic [atrc_pkg::PLEN_W-1:0]              plen,
   output atrc_pkg::match_type                          hit
);

   logic [atrc_pkg::WIN-1:0] len_hit;

   always_comb begin
      len_hit = '1;
      for (int k = 0; k < atrc_pkg::WIN; k++) begin
         for (int i = 0; i < atrc_pkg::WIN; i++) begin
            if (i <= k) begin
               if (window[4'(k - i)] != pattern[i*atrc_pkg::BYTE_W +: atrc_pkg::BYTE_W]) begin
                  len_hit[k] = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      if (plen == '0) begin
         hit.expected = 1'b1;
      end else begin
         hit.expected = len_hit[4'(plen - 5'd1)] && (count >= CNT_W'(plen));
      end
      hit.connect_fail = (count >= CNT_W'(atrc_pkg::FAIL_LEN)) &&
                         (window[atrc_pkg::FAIL_LEN-1:0] == atrc_pkg::FAIL_TEXT);
      hit.closed       = (count >= CNT_W'(atrc_pkg::CLOSED_LEN)) &&
                         (window[atrc_pkg::CLOSED_LEN-1:0] == atrc_pkg::CLOSED_TEXT);
   end

endmodule

`default_nettype wire

// ----- rtl/at_reply_line_classifier.sv -----
// ----------------------------------------------------------------------------
// at_reply_line_classifier
// Classifies modem reply lines one received byte at a time: send prompt,
// blank line, reply matched or unmatched, server data and buffer overflow.
//
//   channel   ports                   direction   payload
//   request   req_valid/req_ready     in          rx_byte
//   response  rsp_valid/rsp_ready     out         event_res, connect_fail,
//                                                 link_closed, line_length,
//                                                 overflowed
//   config    psel/penable/pwrite     in          expected reply, length
//
// One request per cycle while responses are taken, one response per request;
// a request passes an input register, then the line state update and result register.
// The response register and the input register decouple the two sides; a
// stalled response holds both stages while they are full.
// Reset clears the line count and match flags and loads the default expected reply "OK".
// ----------------------------------------------------------------------------
`default_nettype none

module at_reply_line_classifier #(
   parameter int LINE_MAX    = atrc_pkg::LINE_MAX_DEF,
   parameter int PATTERN_MAX = atrc_pkg::PATTERN_MAX_DEF
) (
   input  var logic                                clock,
   input  var logic                                reset,

   input  var logic                                req_valid,
   output logic                                    req_ready,
   input  var logic [atrc_pkg::BYTE_W-1:0]         req_rx_byte,

   output logic                                    rsp_valid,
   input  var logic                                rsp_ready,
   output logic [atrc_pkg::EVENT_W-1:0]            rsp_event_res,
   output logic                                    rsp_connect_fail,
   output logic                                    rsp_link_closed,
   output logic [atrc_pkg::LENGTH_W-1:0]           rsp_line_length,
   output logic                                    rsp_overflowed,

   input  var logic                                psel,
   input  var logic                                penable,
   input  var logic                                pwrite,
   input  var logic [atrc_pkg::ADDR_W-1:0]         paddr,
   input  var logic [atrc_pkg::DATA_W-1:0]         pwdata,
   output logic [atrc_pkg::DATA_W-1:0]             prdata,
   output logic                                    pready
);

   localparam int CNT_W = $clog2(LINE_MAX + 1);

   logic [atrc_pkg::DATA_W-1:0] expect_low_ff;
   logic [atrc_pkg::DATA_W-1:0] expect_high_ff;
   logic [atrc_pkg::PLEN_W-1:0] expect_len_ff;
   logic [atrc_pkg::INDEX_W-1:0] reg_index;
   logic                         reg_write;

   logic                        in_valid_ff;
   logic [atrc_pkg::BYTE_W-1:0] in_byte_ff;
   logic                        advance;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   atrc_pkg::window_type window_ff;
   atrc_pkg::window_type window_in;
   logic                 seen_expected_ff;
   logic                 seen_fail_ff;
   logic                 seen_closed_ff;
   logic                 seen_expected_in;
   logic                 seen_fail_in;
   logic                 seen_closed_in;

   logic                        rsp_valid_ff;
   logic [atrc_pkg::EVENT_W-1:0] rsp_event_ff;
   logic [atrc_pkg::EVENT_W-1:0] rsp_event_in;
   logic                         rsp_fail_ff;
   logic                         rsp_fail_in;
   logic                         rsp_closed_ff;
   logic                         rsp_closed_in;
   logic [atrc_pkg::LENGTH_W-1:0] rsp_length_ff;
   logic [atrc_pkg::LENGTH_W-1:0] rsp_length_in;
   logic                          rsp_ovf_ff;

   logic                         overflow;
   logic [CNT_W-1:0]             line_count;
   logic [atrc_pkg::PLEN_W-1:0]  plen;
   logic                         has_prev;
   logic [atrc_pkg::BYTE_W-1:0]  prev_byte;
   logic                         crlf;
   logic                         restart;
   atrc_pkg::match_type          hit;

   // configuration port
   assign pready    = 1'b1;
   assign reg_index = paddr[atrc_pkg::ADDR_W-1:atrc_pkg::ADDR_W-atrc_pkg::INDEX_W];
   assign reg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_low_ff  <= atrc_pkg::EXPECT_LOW_RST;
         expect_high_ff <= atrc_pkg::EXPECT_HIGH_RST;
         expect_len_ff  <= atrc_pkg::EXPECT_LEN_RST;
      end else if (reg_write) begin
         unique case (reg_index)
            atrc_pkg::REG_EXPECT_LOW:  expect_low_ff  <= pwdata;
            atrc_pkg::REG_EXPECT_HIGH: expect_high_ff <= pwdata;
            atrc_pkg::REG_EXPECT_LEN:  expect_len_ff  <= pwdata[atrc_pkg::PLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         atrc_pkg::REG_EXPECT_LOW:  prdata = expect_low_ff;
         atrc_pkg::REG_EXPECT_HIGH: prdata = expect_high_ff;
         atrc_pkg::REG_EXPECT_LEN:  prdata = atrc_pkg::DATA_W'(expect_len_ff);
         default:                   prdata = '0;
      endcase
   end

   // handshake
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // line state update
   assign overflow   = count_ff >= CNT_W'(LINE_MAX);
   assign line_count = (overflow ? '0 : count_ff) + CNT_W'(1);
   assign window_in  = {window_ff[atrc_pkg::WIN-2:0], in_byte_ff};
   assign plen       = (expect_len_ff > atrc_pkg::PLEN_W'(PATTERN_MAX)) ?
                       atrc_pkg::PLEN_W'(PATTERN_MAX) : expect_len_ff;

   atrc_match #(
      .CNT_W (CNT_W)
   ) u_match (
      .window  (window_in),
      .count   (line_count),
      .pattern ({expect_high_ff, expect_low_ff}),
      .plen    (plen),
      .hit     (hit)
   );

   assign has_prev  = line_count >= CNT_W'(2);
   assign prev_byte = window_ff[0];
   assign crlf      = has_prev && (prev_byte == atrc_pkg::CHAR_CR) &&
                      (in_byte_ff == atrc_pkg::CHAR_LF);

   always_comb begin
      seen_expected_in = (!overflow && seen_expected_ff) || hit.expected;
      seen_fail_in     = (!overflow && seen_fail_ff) || hit.connect_fail;
      seen_closed_in   = (!overflow && seen_closed_ff) || hit.closed;
      rsp_event_in     = atrc_pkg::EV_NONE;
      rsp_fail_in      = 1'b0;
      rsp_closed_in    = 1'b0;
      rsp_length_in    = '0;
      restart          = 1'b1;
      if (has_prev && (prev_byte == atrc_pkg::CHAR_GT) &&
          (in_byte_ff == atrc_pkg::CHAR_SPACE)) begin
         rsp_event_in = atrc_pkg::EV_PROMPT;
      end else if (crlf && (line_count < CNT_W'(atrc_pkg::BLANK_LIMIT))) begin
         rsp_event_in = atrc_pkg::EV_BLANK;
      end else if (crlf) begin
         rsp_length_in = atrc_pkg::LENGTH_W'(line_count);
         if (seen_expected_in) begin
            rsp_event_in = atrc_pkg::EV_MATCHED;
         end else begin
            rsp_event_in  = atrc_pkg::EV_UNMATCHED;
            rsp_fail_in   = seen_fail_in;
            rsp_closed_in = seen_closed_in;
         end
      end else if (has_prev && (line_count > CNT_W'(atrc_pkg::DATA_LIMIT)) &&
                   (prev_byte != atrc_pkg::CHAR_CR) &&
                   (in_byte_ff == atrc_pkg::CHAR_LF)) begin
         rsp_event_in  = atrc_pkg::EV_SERVER;
         rsp_length_in = atrc_pkg::LENGTH_W'(line_count);
      end else begin
         restart = 1'b0;
      end
      count_in = restart ? '0 : line_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         seen_expected_ff <= 1'b0;
         seen_fail_ff     <= 1'b0;
         seen_closed_ff   <= 1'b0;
      end else if (advance) begin
         count_ff         <= count_in;
         seen_expected_ff <= seen_expected_in && !restart;
         seen_fail_ff     <= seen_fail_in && !restart;
         seen_closed_ff   <= seen_closed_in && !restart;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         window_ff <= window_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_event_ff  <= rsp_event_in;
         rsp_fail_ff   <= rsp_fail_in;
         rsp_closed_ff <= rsp_closed_in;
         rsp_length_ff <= rsp_length_in;
         rsp_ovf_ff    <= overflow;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_event_ff;
   assign rsp_connect_fail = rsp_fail_ff;
   assign rsp_link_closed  = rsp_closed_ff;
   assign rsp_line_length  = rsp_length_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

endmodule

`default_nettype wire
